// ----- sv/hor_pkg.sv -----
// Shared types and constants for the histogram overlap rebin block.
// Used by hor_div and histogram_overlap_rebin_top; no dependencies.
package hor_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 13;
    localparam int EDGE_W  = 32;
    localparam int COUNT_W = 32;
    localparam int SUM_W   = 48;
    localparam int NBIN_W  = 12;
    localparam int CFG_W   = 13;
    localparam int DIVD_W  = 48;
    localparam int DIVS_W  = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [IDX_W-1:0]          edge_index;
        logic signed [EDGE_W-1:0]  edge_value;
        logic signed [COUNT_W-1:0] bin_count;
    } in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] bin_sum;
        logic [NBIN_W-1:0]       new_bin_index;
        logic                    status;
    } out_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_DIV,
        S_SW_ISSUE,
        S_SW_CHK,
        S_AC_ISSUE,
        S_AC_CHK,
        S_MUL_LO,
        S_MUL_HI,
        S_TERM,
        S_ACC,
        S_DONE
    } state_t;

endpackage

// ----- sv/hor_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on hor_pkg.
module hor_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hor_pkg::div_req_t         req,
    output logic                      done,
    output logic [hor_pkg::DIVD_W-1:0] quotient
);
    import hor_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [5:0]        step_reg, step_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [DIVS_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            step_next = step_reg + 6'd1;
            if (step_reg == 6'(DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/histogram_overlap_rebin_top.sv -----
// Histogram overlap rebin: top level with edge/density memories and sequencer.
// Depends on hor_pkg and hor_div.
// Load: index 0 writes the edge and clears the invalid flag; else a bad width stores zero
// density and sets the flag, and a good one divides. New edge: skips bins left of it, then
// accumulates each overlapping bin, waiting while the output register is full.
// One at a time. Reset clears control; memories undefined.
module histogram_overlap_rebin_top #(
    parameter int MAX_OLD_BINS = 4096,
    parameter int MAX_NEW_BINS = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hor_pkg::in_t              in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hor_pkg::out_t             out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [hor_pkg::CFG_W-1:0] cfg_data
);
    import hor_pkg::*;

    localparam int EAW  = $clog2(MAX_OLD_BINS + 1);
    localparam int DAW  = (MAX_OLD_BINS > 1) ? $clog2(MAX_OLD_BINS) : 1;
    localparam int CNTW = (MAX_NEW_BINS > 1) ? $clog2(MAX_NEW_BINS) : 1;

    logic signed [EDGE_W-1:0] edge_mem [MAX_OLD_BINS+1];
    logic signed [SUM_W-1:0]  dens_mem [MAX_OLD_BINS];

    logic                     e_we;
    logic [EAW-1:0]           e_wa, ea_addr, eb_addr;
    logic signed [EDGE_W-1:0] e_wd, ea_q, eb_q;
    logic                     d_we;
    logic [DAW-1:0]           d_wa, d_ra;
    logic signed [SUM_W-1:0]  d_wd, d_q;

    state_t                   state_reg, state_next;
    logic [CFG_W-1:0]         cfg_reg;
    logic [EAW-1:0]           sp_reg, sp_next;
    logic [EAW-1:0]           j_reg, j_next;
    logic signed [EDGE_W-1:0] left_reg, left_next;
    logic signed [EDGE_W-1:0] right_reg, right_next;
    logic signed [EDGE_W-1:0] prev_reg, prev_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SUM_W-1:0]  term_reg, term_next;
    logic [CNTW-1:0]          nbin_reg, nbin_next;
    logic                     inv_reg, inv_next;
    logic signed [EDGE_W-1:0] ev_reg, ev_next;
    logic                     cneg_reg, cneg_next;
    logic [COUNT_W-1:0]       cmag_reg, cmag_next;
    logic [DAW-1:0]           didx_reg, didx_next;
    logic [SUM_W-1:0]         dmag_reg, dmag_next;
    logic                     dneg_reg, dneg_next;
    logic [EDGE_W:0]          ov_reg, ov_next;
    logic [56:0]              plo_reg, plo_next, phi_reg, phi_next;
    out_t                     out_reg, out_next;
    logic                     ov_valid_reg, ov_valid_next;

    div_req_t                 div_req;
    logic                     div_done;
    logic [DIVD_W-1:0]        div_q;

    logic [EAW-1:0]           n_lim;
    logic signed [EDGE_W:0]   ld_w;
    logic signed [EDGE_W-1:0] lo, hi;
    logic [80:0]              full;
    logic [64:0]              mag;
    logic signed [SUM_W:0]    s49;
    logic [31:0]              nbin_ext;
    logic                     in_acc;

    hor_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (e_we)
            edge_mem[e_wa] <= e_wd;
        ea_q <= edge_mem[ea_addr];
        eb_q <= edge_mem[eb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
            dens_mem[d_wa] <= d_wd;
        d_q <= dens_mem[d_ra];
    end

    assign n_lim    = (32'(cfg_reg) > MAX_OLD_BINS) ? EAW'(MAX_OLD_BINS) : EAW'(cfg_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign cfg_ready = (state_reg == S_IDLE);
    assign nbin_ext = 32'(nbin_reg);

    always_comb
    begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        j_next        = j_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        prev_next     = prev_reg;
        sum_next      = sum_reg;
        term_next     = term_reg;
        nbin_next     = nbin_reg;
        inv_next      = inv_reg;
        ev_next       = ev_reg;
        cneg_next     = cneg_reg;
        cmag_next     = cmag_reg;
        didx_next     = didx_reg;
        dmag_next     = dmag_reg;
        dneg_next     = dneg_reg;
        ov_next       = ov_reg;
        plo_next      = plo_reg;
        phi_next      = phi_reg;
        out_next      = out_reg;
        ov_valid_next = ov_valid_reg && !out_ready;
        e_we          = 1'b0;
        e_wa          = EAW'(in_data.edge_index);
        e_wd          = in_data.edge_value;
        ea_addr       = '0;
        eb_addr       = '0;
        d_we          = 1'b0;
        d_wa          = didx_reg;
        d_wd          = '0;
        d_ra          = j_reg[DAW-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = {cmag_reg, 16'b0};
        div_req.divisor  = '0;
        ld_w = {ev_reg[EDGE_W-1], ev_reg} - {ea_q[EDGE_W-1], ea_q};
        lo   = (ea_q < left_reg) ? left_reg : ea_q;
        hi   = (eb_q > right_reg) ? right_reg : eb_q;
        full = {phi_reg, 24'b0} + 81'(plo_reg);
        mag  = full[80:16];
        s49  = {sum_reg[SUM_W-1], sum_reg} + {term_reg[SUM_W-1], term_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_data.cmd)
                        CMD_LOAD:
                        begin
                            if (32'(in_data.edge_index) <= MAX_OLD_BINS)
                            begin
                                e_we = 1'b1;
                                if (in_data.edge_index == '0)
                                    inv_next = 1'b0;
                                else
                                begin
                                    ea_addr    = EAW'(in_data.edge_index - 1'b1);
                                    ev_next    = in_data.edge_value;
                                    cneg_next  = in_data.bin_count[COUNT_W-1];
                                    cmag_next  = in_data.bin_count[COUNT_W-1] ?
                                                 COUNT_W'(-in_data.bin_count) :
                                                 COUNT_W'(in_data.bin_count);
                                    didx_next  = DAW'(in_data.edge_index - 1'b1);
                                    state_next = S_LD_RD;
                                end
                            end
                        end
                        CMD_OPEN:
                        begin
                            prev_next = in_data.edge_value;
                            sp_next   = '0;
                            nbin_next = '0;
                        end
                        CMD_NEXT:
                        begin
                            left_next  = prev_reg;
                            right_next = in_data.edge_value;
                            sum_next   = '0;
                            state_next = S_SW_ISSUE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LD_RD:
            begin
                if (ld_w <= 0)
                begin
                    inv_next   = 1'b1;
                    d_we       = 1'b1;
                    d_wd       = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    div_req.start   = 1'b1;
                    div_req.divisor = ld_w[DIVS_W-1:0];
                    state_next      = S_LD_DIV;
                end
            end
            S_LD_DIV:
            begin
                if (div_done)
                begin
                    d_we       = 1'b1;
                    d_wd       = cneg_reg ? -$signed(div_q) : $signed(div_q);
                    state_next = S_IDLE;
                end
            end
            S_SW_ISSUE:
            begin
                if (sp_reg < n_lim)
                begin
                    ea_addr    = sp_reg + 1'b1;
                    state_next = S_SW_CHK;
                end
                else
                begin
                    j_next     = sp_reg;
                    state_next = S_AC_ISSUE;
                end
            end
            S_SW_CHK:
            begin
                if (ea_q <= left_reg)
                begin
                    sp_next    = sp_reg + 1'b1;
                    state_next = S_SW_ISSUE;
                end
                else
                begin
                    j_next     = sp_reg;
                    state_next = S_AC_ISSUE;
                end
            end
            S_AC_ISSUE:
            begin
                if (j_reg < n_lim)
                begin
                    ea_addr    = j_reg;
                    eb_addr    = j_reg + 1'b1;
                    state_next = S_AC_CHK;
                end
                else
                    state_next = S_DONE;
            end
            S_AC_CHK:
            begin
                if (ea_q < right_reg)
                begin
                    if (hi > lo)
                    begin
                        ov_next    = {hi[EDGE_W-1], hi} - {lo[EDGE_W-1], lo};
                        dneg_next  = d_q[SUM_W-1];
                        dmag_next  = d_q[SUM_W-1] ? SUM_W'(-d_q) : SUM_W'(d_q);
                        state_next = S_MUL_LO;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_AC_ISSUE;
                    end
                end
                else
                    state_next = S_DONE;
            end
            S_MUL_LO:
            begin
                plo_next   = 57'(dmag_reg[23:0]) * 57'(ov_reg);
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                phi_next   = 57'(dmag_reg[47:24]) * 57'(ov_reg);
                state_next = S_TERM;
            end
            S_TERM:
            begin
                if (dneg_reg)
                    term_next = (mag >= 65'h8000_0000_0000) ? SUM_MIN :
                                -$signed(mag[SUM_W-1:0]);
                else
                    term_next = (mag > 65'h7FFF_FFFF_FFFF) ? SUM_MAX :
                                $signed(mag[SUM_W-1:0]);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (s49[SUM_W] != s49[SUM_W-1])
                    sum_next = s49[SUM_W] ? SUM_MIN : SUM_MAX;
                else
                    sum_next = s49[SUM_W-1:0];
                j_next     = j_reg + 1'b1;
                state_next = S_AC_ISSUE;
            end
            S_DONE:
            begin
                if (!ov_valid_reg || out_ready)
                begin
                    out_next.bin_sum       = sum_reg;
                    out_next.new_bin_index = nbin_ext[NBIN_W-1:0];
                    out_next.status        = inv_reg;
                    ov_valid_next          = 1'b1;
                    prev_next              = right_reg;
                    nbin_next = (32'(nbin_reg) == MAX_NEW_BINS - 1) ? '0 : nbin_reg + 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cfg_reg      <= CFG_RESET;
            sp_reg       <= '0;
            j_reg        <= '0;
            left_reg     <= '0;
            right_reg    <= '0;
            prev_reg     <= '0;
            sum_reg      <= '0;
            term_reg     <= '0;
            nbin_reg     <= '0;
            inv_reg      <= 1'b0;
            ev_reg       <= '0;
            cneg_reg     <= 1'b0;
            cmag_reg     <= '0;
            didx_reg     <= '0;
            dmag_reg     <= '0;
            dneg_reg     <= 1'b0;
            ov_reg       <= '0;
            plo_reg      <= '0;
            phi_reg      <= '0;
            out_reg      <= '0;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_valid && cfg_ready)
                cfg_reg <= cfg_data;
            sp_reg       <= sp_next;
            j_reg        <= j_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            prev_reg     <= prev_next;
            sum_reg      <= sum_next;
            term_reg     <= term_next;
            nbin_reg     <= nbin_next;
            inv_reg      <= inv_next;
            ev_reg       <= ev_next;
            cneg_reg     <= cneg_next;
            cmag_reg     <= cmag_next;
            didx_reg     <= didx_next;
            dmag_reg     <= dmag_next;
            dneg_reg     <= dneg_next;
            ov_reg       <= ov_next;
            plo_reg      <= plo_next;
            phi_reg      <= phi_next;
            out_reg      <= out_next;
            ov_valid_reg <= ov_valid_next;
        end
    end

    assign out_valid = ov_valid_reg;
    assign out_data  = out_reg;

    a_div_done_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_LD_DIV)
        else $error("divider finished outside a load");

    a_acc_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_AC_CHK |-> j_reg < n_lim)
        else $error("accumulate index past bin count");

    a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!ov_valid_reg || out_ready))
            |=> (ov_valid_reg && state_reg == S_IDLE))
        else $error("finished new-edge transaction did not emit a result");

endmodule
